[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on i_clk outside reset
`define DRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define DRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DRT_ASSERT_IMP(lbl, ante, cons, msg)
`define DRT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[sv/drttl_pkg.sv]
// ----------------------------------------------------------------------------
// drttl_pkg
// Shared constants for the DNS response TTL zeroing unit
// ----------------------------------------------------------------------------
`default_nettype none

package drttl_pkg;

    // payload widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned QCOUNT_W  = 16;
    localparam int unsigned RCOUNT_W  = 18;
    localparam int unsigned LABEL_W   = 6;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned RTYPE_W   = 16;
    localparam int unsigned RDLEN_W   = 16;

    // message layout
    localparam logic [POS_W-1:0]   HEADER_LEN = 4'd12;
    localparam logic [POS_W-1:0]   QFIXED_LEN = 4'd4;
    localparam logic [POS_W-1:0]   RFIXED_LEN = 4'd10;
    localparam logic [RTYPE_W-1:0] OPT_TYPE   = 16'd41;
    localparam logic [BYTE_W-1:0]  PTR_MASK   = 8'hC0;

    // header byte offsets
    localparam logic [POS_W-1:0] HDR_QD_HI = 4'd4;
    localparam logic [POS_W-1:0] HDR_QD_LO = 4'd5;
    localparam logic [POS_W-1:0] HDR_AN_HI = 4'd6;
    localparam logic [POS_W-1:0] HDR_AN_LO = 4'd7;
    localparam logic [POS_W-1:0] HDR_NS_HI = 4'd8;
    localparam logic [POS_W-1:0] HDR_NS_LO = 4'd9;
    localparam logic [POS_W-1:0] HDR_AR_HI = 4'd10;
    localparam logic [POS_W-1:0] HDR_AR_LO = 4'd11;

    // record fixed block offsets
    localparam logic [POS_W-1:0] FIX_TYPE_HI  = 4'd0;
    localparam logic [POS_W-1:0] FIX_TYPE_LO  = 4'd1;
    localparam logic [POS_W-1:0] FIX_TTL_0    = 4'd4;
    localparam logic [POS_W-1:0] FIX_TTL_3    = 4'd7;
    localparam logic [POS_W-1:0] FIX_RDLEN_HI = 4'd8;
    localparam logic [POS_W-1:0] FIX_RDLEN_LO = 4'd9;

endpackage

`default_nettype wire

[sv/drttl_if.sv]
// ----------------------------------------------------------------------------
// drttl_if
// Valid/ready stream interfaces for message bytes in and rewritten bytes out
// ----------------------------------------------------------------------------
`default_nettype none

interface drttl_in_if
    import drttl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface drttl_out_if
    import drttl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic              packet_ok;

    modport source (output valid, output out_byte, output out_last, output packet_ok,
                     input ready);
    modport sink   (input valid, input out_byte, input out_last, input packet_ok,
                    output ready);
endinterface

`default_nettype wire

[sv/dns_response_ttl_zeroing_unit.sv]
// ----------------------------------------------------------------------------
// dns_response_ttl_zeroing_unit
// Walks a DNS message byte stream, zeroes non-OPT record TTLs and flags parse success
// ----------------------------------------------------------------------------
//  port    dir  word                                   handshake
//  i_in    in   data_byte[8], end_of_packet            valid/ready
//  o_out   out  out_byte[8], out_last, packet_ok       valid/ready
//
//  One word per cycle while the output is not stalled: the parser update is one
//  step of logic between the walk state registers and the output register.
//  A new word is taken whenever the output register is empty or being drained.
//  Synchronous active-low reset clears the walk state and output valid; the
//  walk state also returns to the header phase after every final byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dns_response_ttl_zeroing_unit
    import drttl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    drttl_in_if.sink    i_in,
    drttl_out_if.source o_out
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_LABEL,
        PH_POINTER,
        PH_FIXED,
        PH_RDATA,
        PH_DONE
    } t_phase;

    // walk state
    t_phase              r_phase,     n_phase;
    logic [POS_W-1:0]    r_hdr_pos,   n_hdr_pos;
    logic [QCOUNT_W-1:0] r_q_left,    n_q_left;
    logic [RCOUNT_W-1:0] r_r_left,    n_r_left;
    logic [LABEL_W-1:0]  r_lbl_left,  n_lbl_left;
    logic [POS_W-1:0]    r_fix_pos,   n_fix_pos;
    logic [RTYPE_W-1:0]  r_rtype,     n_rtype;
    logic [RDLEN_W-1:0]  r_rd_left,   n_rd_left;
    logic                r_failed,    n_failed;

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte,  n_out_byte;
    logic              r_out_last;
    logic              r_out_ok,    n_out_ok;

    logic w_accept;
    logic w_last_take;
    logic w_rearmed;

    // take a word when the output register frees up this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // parser step for one word
    always_comb begin
        logic [BYTE_W-1:0] b;
        b           = i_in.data_byte;
        n_phase     = r_phase;
        n_hdr_pos   = r_hdr_pos;
        n_q_left    = r_q_left;
        n_r_left    = r_r_left;
        n_lbl_left  = r_lbl_left;
        n_fix_pos   = r_fix_pos;
        n_rtype     = r_rtype;
        n_rd_left   = r_rd_left;
        n_failed    = r_failed;
        n_out_byte  = b;
        n_out_ok    = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_hdr_pos == HDR_QD_HI) begin
                    n_q_left = {b, 8'h00};
                end else if (r_hdr_pos == HDR_QD_LO) begin
                    n_q_left = {r_q_left[QCOUNT_W-1:8], b};
                end else if (r_hdr_pos == HDR_AN_HI || r_hdr_pos == HDR_NS_HI
                             || r_hdr_pos == HDR_AR_HI) begin
                    n_rd_left = RDLEN_W'(b);
                end else if (r_hdr_pos == HDR_AN_LO || r_hdr_pos == HDR_NS_LO
                             || r_hdr_pos == HDR_AR_LO) begin
                    n_r_left  = r_r_left + RCOUNT_W'({r_rd_left[BYTE_W-1:0], b});
                    n_rd_left = '0;
                end
                n_hdr_pos = r_hdr_pos + 1'b1;
                if (n_hdr_pos >= HEADER_LEN) begin
                    n_phase = ((n_q_left != '0) || (n_r_left != '0)) ? PH_NAME : PH_DONE;
                end
            end
            PH_NAME: begin
                if (b == '0) begin
                    n_phase   = PH_FIXED;
                    n_fix_pos = '0;
                end else if ((b & PTR_MASK) == PTR_MASK) begin
                    n_phase = PH_POINTER;
                end else if ((b & PTR_MASK) != '0) begin
                    n_failed = 1'b1;
                    n_phase  = PH_DONE;
                end else begin
                    n_lbl_left = b[LABEL_W-1:0];
                    n_phase    = PH_LABEL;
                end
            end
            PH_LABEL: begin
                n_lbl_left = r_lbl_left - 1'b1;
                if (n_lbl_left == '0) begin
                    n_phase = PH_NAME;
                end
            end
            PH_POINTER: begin
                n_phase   = PH_FIXED;
                n_fix_pos = '0;
            end
            PH_FIXED: begin
                if (r_q_left != '0) begin
                    // question: type and class only
                    n_fix_pos = r_fix_pos + 1'b1;
                    if (n_fix_pos >= QFIXED_LEN) begin
                        n_q_left  = r_q_left - 1'b1;
                        n_fix_pos = '0;
                        n_phase   = ((n_q_left != '0) || (r_r_left != '0)) ? PH_NAME
                                                                            : PH_DONE;
                    end
                end else begin
                    // resource record fixed block
                    if (r_fix_pos == FIX_TYPE_HI) begin
                        n_rtype = {b, 8'h00};
                    end else if (r_fix_pos == FIX_TYPE_LO) begin
                        n_rtype = {r_rtype[RTYPE_W-1:8], b};
                    end else if (r_fix_pos >= FIX_TTL_0 && r_fix_pos <= FIX_TTL_3) begin
                        if (r_rtype != OPT_TYPE) begin
                            n_out_byte = '0;
                        end
                    end else if (r_fix_pos == FIX_RDLEN_HI) begin
                        n_rd_left = {b, 8'h00};
                    end else if (r_fix_pos == FIX_RDLEN_LO) begin
                        n_rd_left = {r_rd_left[RDLEN_W-1:8], b};
                    end
                    n_fix_pos = r_fix_pos + 1'b1;
                    if (n_fix_pos >= RFIXED_LEN) begin
                        n_fix_pos = '0;
                        if (n_rd_left == '0) begin
                            n_r_left = r_r_left - 1'b1;
                            n_phase  = ((r_q_left != '0) || (n_r_left != '0)) ? PH_NAME
                                                                             : PH_DONE;
                        end else begin
                            n_phase = PH_RDATA;
                        end
                    end
                end
            end
            PH_RDATA: begin
                n_rd_left = r_rd_left - 1'b1;
                if (n_rd_left == '0) begin
                    n_r_left = r_r_left - 1'b1;
                    n_phase  = ((r_q_left != '0) || (n_r_left != '0)) ? PH_NAME : PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // final byte: report and rearm for the next message
        if (i_in.end_of_packet) begin
            n_out_ok   = (n_phase == PH_DONE) && !n_failed;
            n_phase    = PH_HEADER;
            n_hdr_pos  = '0;
            n_q_left   = '0;
            n_r_left   = '0;
            n_lbl_left = '0;
            n_fix_pos  = '0;
            n_rtype    = '0;
            n_rd_left  = '0;
            n_failed   = 1'b0;
        end
    end

    // walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_pos  <= '0;
            r_q_left   <= '0;
            r_r_left   <= '0;
            r_lbl_left <= '0;
            r_fix_pos  <= '0;
            r_rtype    <= '0;
            r_rd_left  <= '0;
            r_failed   <= 1'b0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_hdr_pos  <= n_hdr_pos;
            r_q_left   <= n_q_left;
            r_r_left   <= n_r_left;
            r_lbl_left <= n_lbl_left;
            r_fix_pos  <= n_fix_pos;
            r_rtype    <= n_rtype;
            r_rd_left  <= n_rd_left;
            r_failed   <= n_failed;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_byte <= n_out_byte;
            r_out_last <= i_in.end_of_packet;
            r_out_ok   <= n_out_ok;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.out_last  = r_out_last;
    assign o_out.packet_ok = r_out_ok;

    // checks
    assign w_last_take = w_accept && i_in.end_of_packet;
    assign w_rearmed   = (r_phase == PH_HEADER) && (r_hdr_pos == '0) && !r_failed;

    `DRT_ASSERT_IMP(a_ok_only_on_last, r_out_valid && r_out_ok, r_out_last, "ok without last")
    `DRT_ASSERT_NXT(a_rearm_after_last, w_last_take, w_rearmed, "walk not rearmed")
    `DRT_ASSERT_IMP(a_hdr_pos, r_phase == PH_HEADER, r_hdr_pos < HEADER_LEN, "header position")
    `DRT_ASSERT_IMP(a_fix_pos, r_phase == PH_FIXED, r_fix_pos < RFIXED_LEN, "fixed position")
    `DRT_ASSERT_IMP(a_label_nonzero, r_phase == PH_LABEL, r_lbl_left != '0, "empty label count")
    `DRT_ASSERT_IMP(a_failed_is_done, r_failed, r_phase == PH_DONE, "failed walk active")

endmodule

`default_nettype wire

[bench/ttl_rewrite_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_rewrite_checker
// Watches both byte channels, walks each message in step with the unit,
// predicts every rewritten word and compares it in order with the output
// ----------------------------------------------------------------------------
module ttl_rewrite_checker
    import drttl_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    drttl_in_if  i_in,
    drttl_out_if i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_NAME,
        WALK_LABEL,
        WALK_POINTER,
        WALK_FIXED,
        WALK_RDATA,
        WALK_DONE
    } t_walk_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic              packet_ok;
    } t_rewrite_word;

    // walk state of the predictor
    t_walk_phase         walk;
    logic [POS_W-1:0]    hdr_pos;
    logic [POS_W-1:0]    fix_pos;
    logic [QCOUNT_W-1:0] questions;
    logic [RCOUNT_W-1:0] records;
    logic [LABEL_W-1:0]  label_left;
    logic [RTYPE_W-1:0]  rr_type;
    logic [RDLEN_W-1:0]  rdata_left;
    logic                failed;

    t_rewrite_word expected_words[$];
    int            fail_count = 0;

    task automatic restart_walk();
        walk       = WALK_HEADER;
        hdr_pos    = '0;
        fix_pos    = '0;
        questions  = '0;
        records    = '0;
        label_left = '0;
        rr_type    = '0;
        rdata_left = '0;
        failed     = 1'b0;
    endtask

    // go on to the next question or record, or finish the walk
    task automatic next_section();
        walk = (questions != 0 || records != 0) ? WALK_NAME : WALK_DONE;
    endtask

    // advance the walk by one byte and form the word it yields
    task automatic rewrite_byte(input logic [BYTE_W-1:0] b, input logic last,
                                output t_rewrite_word w);
        logic [BYTE_W-1:0] ob;
        logic              ok;
        ob = b;
        ok = 1'b0;
        case (walk)
            WALK_HEADER: begin
                case (hdr_pos)
                    HDR_QD_HI: questions = {b, 8'h00};
                    HDR_QD_LO: questions = questions | {8'h00, b};
                    HDR_AN_HI, HDR_NS_HI, HDR_AR_HI: rdata_left = {8'h00, b};
                    HDR_AN_LO, HDR_NS_LO, HDR_AR_LO: begin
                        records    = records + {2'b00, rdata_left[7:0], b};
                        rdata_left = '0;
                    end
                    default: ;
                endcase
                hdr_pos = hdr_pos + 1'b1;
                if (hdr_pos >= HEADER_LEN) next_section();
            end
            WALK_NAME: begin
                if (b == 8'h00) begin
                    walk    = WALK_FIXED;
                    fix_pos = '0;
                end else if ((b & PTR_MASK) == PTR_MASK) begin
                    walk = WALK_POINTER;
                end else if ((b & PTR_MASK) != 8'h00) begin
                    failed = 1'b1;
                    walk   = WALK_DONE;
                end else begin
                    label_left = b[LABEL_W-1:0];
                    walk       = WALK_LABEL;
                end
            end
            WALK_LABEL: begin
                label_left = label_left - 1'b1;
                if (label_left == 0) walk = WALK_NAME;
            end
            WALK_POINTER: begin
                walk    = WALK_FIXED;
                fix_pos = '0;
            end
            WALK_FIXED: begin
                if (questions != 0) begin
                    // question: type and class only
                    fix_pos = fix_pos + 1'b1;
                    if (fix_pos >= QFIXED_LEN) begin
                        questions = questions - 1'b1;
                        fix_pos   = '0;
                        next_section();
                    end
                end else begin
                    // record: type, class, ttl, rdlength
                    if (fix_pos == FIX_TYPE_HI) begin
                        rr_type = {b, 8'h00};
                    end else if (fix_pos == FIX_TYPE_LO) begin
                        rr_type = rr_type | {8'h00, b};
                    end else if (fix_pos >= FIX_TTL_0 && fix_pos <= FIX_TTL_3) begin
                        if (rr_type != OPT_TYPE) ob = 8'h00;
                    end else if (fix_pos == FIX_RDLEN_HI) begin
                        rdata_left = {b, 8'h00};
                    end else if (fix_pos == FIX_RDLEN_LO) begin
                        rdata_left = rdata_left | {8'h00, b};
                    end
                    fix_pos = fix_pos + 1'b1;
                    if (fix_pos >= RFIXED_LEN) begin
                        fix_pos = '0;
                        if (rdata_left == 0) begin
                            records = records - 1'b1;
                            next_section();
                        end else begin
                            walk = WALK_RDATA;
                        end
                    end
                end
            end
            WALK_RDATA: begin
                rdata_left = rdata_left - 1'b1;
                if (rdata_left == 0) begin
                    records = records - 1'b1;
                    next_section();
                end
            end
            default: ;
        endcase
        if (last) begin
            ok = (walk == WALK_DONE && !failed);
            restart_walk();
        end
        w = '{out_byte: ob, out_last: last, packet_ok: ok};
    endtask

    // follow both channels; an output word belongs to an earlier input word
    always @(posedge i_clk) begin : monitor
        t_rewrite_word got;
        t_rewrite_word want;
        if (!i_rst_n) begin
            restart_walk();
            expected_words.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{out_byte: i_out.out_byte, out_last: i_out.out_last,
                        packet_ok: i_out.packet_ok};
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: byte %h last %b ok %b",
                                 got.out_byte, got.out_last, got.packet_ok);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: want %h/%b/%b got %h/%b/%b",
                                     want.out_byte, want.out_last, want.packet_ok,
                                     got.out_byte, got.out_last, got.packet_ok);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                rewrite_byte(i_in.data_byte, i_in.end_of_packet, want);
                expected_words.insert(expected_words.size(), want);
            end
            o_pending    <= expected_words.size();
            o_fail_count <= fail_count;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds DNS messages byte by byte into the TTL zeroing unit: a few fixed
// short messages, then random well-formed, truncated, bad-label and noise
// messages, with random gaps on both channels and one long output stall
// ----------------------------------------------------------------------------
module testbench;
    import drttl_pkg::*;

    typedef enum {
        MSG_GOOD,
        MSG_TRUNC,
        MSG_BAD_LABEL,
        MSG_NOISE
    } t_msg_kind;

    localparam logic [BYTE_W-1:0] NAME_END   = 8'h00;
    localparam int                BYTE_TOTAL = 800;
    localparam int                HALF_WAY   = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    drttl_in_if  in_ch();
    drttl_out_if out_ch();

    int fail_count;
    int pending;
    int bytes_sent = 0;
    bit bad_label_due = 1'b0;

    logic [BYTE_W-1:0] msg_q[$];

    dns_response_ttl_zeroing_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ttl_rewrite_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // run limit
    initial begin
        #(40_000_000);
        $display("status: fail");
        $finish;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // append one byte to the message being built
    task automatic add_byte(input logic [BYTE_W-1:0] b);
        msg_q.insert(msg_q.size(), b);
    endtask

    // labels, an optional bad length byte, then a zero or a pointer
    task automatic put_name();
        int labels;
        int len;
        labels = $urandom_range(0, 3);
        repeat (labels) begin
            len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 5);
            add_byte(8'(len));
            repeat (len) add_byte(8'($urandom));
        end
        if (bad_label_due) begin
            add_byte(8'($urandom_range(8'h40, 8'hBF)));
            bad_label_due = 1'b0;
        end
        if ($urandom_range(0, 2) == 0) begin
            add_byte(PTR_MASK | 8'($urandom_range(0, 63)));
            add_byte(8'($urandom));
        end else begin
            add_byte(NAME_END);
        end
    endtask

    task automatic build_message(input t_msg_kind kind);
        int                 qd;
        int                 an;
        int                 ns;
        int                 ar;
        int                 cut;
        int                 n;
        logic [RDLEN_W-1:0] rdlen;
        msg_q.delete();
        if (kind == MSG_NOISE) begin
            n = $urandom_range(1, 24);
            repeat (n) add_byte(8'($urandom));
        end else begin
            qd = $urandom_range(0, 2);
            an = $urandom_range(0, 2);
            ns = $urandom_range(0, 1);
            ar = $urandom_range(0, 1);
            if (kind == MSG_BAD_LABEL) begin
                qd = qd + 1;
                bad_label_due = 1'b1;
            end
            // header: id and flags, then the four counts
            repeat (4) add_byte(8'($urandom));
            add_byte(8'(qd >> 8));
            add_byte(8'(qd));
            add_byte(8'(an >> 8));
            add_byte(8'(an));
            add_byte(8'(ns >> 8));
            add_byte(8'(ns));
            add_byte(8'(ar >> 8));
            add_byte(8'(ar));
            repeat (qd) begin
                put_name();
                repeat (4) add_byte(8'($urandom));
            end
            repeat (an + ns + ar) begin
                put_name();
                if ($urandom_range(0, 3) == 0) begin
                    add_byte(OPT_TYPE[15:8]);
                    add_byte(OPT_TYPE[7:0]);
                end else begin
                    repeat (2) add_byte(8'($urandom));
                end
                // class and ttl
                repeat (6) add_byte(8'($urandom));
                rdlen = ($urandom_range(0, 15) == 0) ? RDLEN_W'($urandom_range(6, 40))
                                                      : RDLEN_W'($urandom_range(0, 4));
                add_byte(rdlen[15:8]);
                add_byte(rdlen[7:0]);
                repeat (rdlen) add_byte(8'($urandom));
            end
            // trailing bytes
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
            if (kind == MSG_TRUNC && msg_q.size() > 1) begin
                cut = $urandom_range(1, msg_q.size() - 1);
                while (msg_q.size() > cut) msg_q.delete(msg_q.size() - 1);
            end
        end
    endtask

    // offer one word and wait for it to be taken
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_packet <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message();
        bit steady;
        int gap;
        steady = ($urandom_range(0, 3) == 0);
        foreach (msg_q[i]) begin
            gap = steady ? 0 : pick_gap();
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            send_word(msg_q[i], i == msg_q.size() - 1);
        end
    endtask

    // output side: random stalls, long open runs, and one long hold-off
    initial begin : drain_side
        int stall_len;
        int run_len;
        int phase_n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        phase_n = 0;
        forever begin
            phase_n++;
            stall_len = (phase_n == 40) ? 300 : pick_gap();
            if (stall_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 6);
            out_ch.ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
        end
    end

    // reset, stimulus and verdict
    initial begin : stimulus
        t_msg_kind kind;
        int        pick;
        bit        paused;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.end_of_packet <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // header only, all counts zero: parses
        msg_q.delete();
        repeat (4) add_byte(8'hFF);
        repeat (8) add_byte(8'h00);
        send_message();
        // one-byte message: ends inside the header
        msg_q.delete();
        add_byte(8'h00);
        send_message();
        // short message of all-ones bytes
        msg_q.delete();
        repeat (5) add_byte(8'hFF);
        send_message();

        paused = 1'b0;
        while (bytes_sent < BYTE_TOTAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      kind = MSG_GOOD;
            else if (pick < 75) kind = MSG_TRUNC;
            else if (pick < 85) kind = MSG_BAD_LABEL;
            else                kind = MSG_NOISE;
            build_message(kind);
            send_message();
            // hold the input once until the output has caught up
            if (!paused && bytes_sent >= HALF_WAY) begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/drttl_pkg.sv
sv/drttl_if.sv
sv/dns_response_ttl_zeroing_unit.sv
bench/ttl_rewrite_checker.sv
bench/testbench.sv
